[design/drkt_pkg.sv]
// Shared types and constants for the dual-role key tap filter.
`timescale 1ns / 1ps
`default_nettype none

package drkt_pkg;

    localparam int CFG_MAP_BITS    = 60;
    localparam int CFG_KEYS_BITS   = 3;
    localparam int CFG_WINDOW_BITS = 24;
    localparam int APB_ADDR_BITS   = 5;
    localparam int APB_DATA_BITS   = 64;

    localparam logic [CFG_MAP_BITS-1:0]    MAP_FROM_RESET = 60'd142000931399063594;
    localparam logic [CFG_MAP_BITS-1:0]    MAP_TO_RESET   = 60'd31526416104350734;
    localparam logic [CFG_KEYS_BITS-1:0]   KEYS_RESET     = 3'd6;
    localparam logic [CFG_WINDOW_BITS-1:0] WINDOW_RESET   = 24'd200000;

    localparam logic [1:0] REG_MAP_FROM   = 2'd0;
    localparam logic [1:0] REG_MAP_TO     = 2'd1;
    localparam logic [1:0] REG_KEYS       = 2'd2;
    localparam logic [1:0] REG_TAP_WINDOW = 2'd3;

    localparam logic [15:0] EV_KEY    = 16'd1;
    localparam logic [15:0] EV_MISC   = 16'd4;
    localparam logic [15:0] SCAN_CODE = 16'd4;

    localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
    localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
    localparam logic signed [31:0] VAL_REPEAT  = 32'sd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PRESSED,
        MODE_TAPPED
    } t_mode;

    typedef enum logic [1:0] {
        BEAT_ORIG,
        BEAT_ALT_PRESS,
        BEAT_ALT_RELEASE
    } t_beat;

    typedef struct packed {
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
        logic [47:0]        time_us;
    } t_evt;

    typedef struct packed {
        t_evt        evt;
        logic [15:0] alt_code;
        logic        three;
    } t_group;

    typedef struct packed {
        logic [CFG_MAP_BITS-1:0]    map_from_codes;
        logic [CFG_MAP_BITS-1:0]    map_to_codes;
        logic [CFG_KEYS_BITS-1:0]   keys_in_use;
        logic [CFG_WINDOW_BITS-1:0] tap_window_us;
    } t_cfg;

endpackage

`default_nettype wire

[design/drkt_stream_if.sv]
// Stream interfaces for input events and emitted result items.
`timescale 1ns / 1ps
`default_nettype none

interface drkt_evt_if;
    logic               valid;
    logic               ready;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic [47:0]        time_us;

    modport source (output valid, event_type, event_code, event_value, time_us,
                    input ready);
    modport sink (input valid, event_type, event_code, event_value, time_us,
                  output ready);
endinterface

interface drkt_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic [47:0]        out_time;
    logic               last_of_run;

    modport source (output valid, out_type, out_code, out_value, out_time, last_of_run,
                    input ready);
    modport sink (input valid, out_type, out_code, out_value, out_time, last_of_run,
                  output ready);
endinterface

`default_nettype wire

[design/dual_role_key_tap_filter.sv]
// Top level of the dual-role key tap filter: input register, core, result sequencer.
// An event item is registered on acceptance and decided once the result register can take
// its result group, which is then loaded into the result register; the first result item
// is offered in the cycle after that. Items that give no result or one result sustain one
// item per cycle while the result channel is ready. A tap release gives three result items,
// played out in turn on the single result channel. Scan events and key repeats are dropped
// in the decision cycle. Per-key state lives in flip-flops and is reset with the block,
// so no clearing pass is needed. Configuration is written over APB at byte address 8*i.
`timescale 1ns / 1ps
`default_nettype none

module dual_role_key_tap_filter import drkt_pkg::*; #(
    parameter int NUM_KEYS  = 6,
    parameter int CODE_BITS = 10,
    parameter int TIME_BITS = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    drkt_evt_if.sink                      i_evt,
    drkt_res_if.source                    o_res
);

    t_cfg   cfg;
    logic   r_in_valid;
    t_evt   r_evt;
    logic   adv;
    logic   can_load;
    logic   has_result;
    t_group grp;

    drkt_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    assign adv         = r_in_valid && can_load;
    assign i_evt.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_evt.event_type  <= i_evt.event_type;
            r_evt.event_code  <= i_evt.event_code;
            r_evt.event_value <= i_evt.event_value;
            r_evt.time_us     <= i_evt.time_us;
        end
    end

    drkt_core #(
        .NUM_KEYS  (NUM_KEYS),
        .CODE_BITS (CODE_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (adv),
        .i_evt        (r_evt),
        .i_cfg        (cfg),
        .o_grp        (grp),
        .o_has_result (has_result)
    );

    drkt_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv && has_result),
        .i_grp      (grp),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

`ifndef SYNTH
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && !o_res.last_of_run |=> o_res.valid)
        else $error("result burst broken before its last item");

    a_burst_is_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.last_of_run |-> o_res.out_type == EV_KEY)
        else $error("non-final result item is not a key event");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_evt))
        else $error("stalled input register changed");

    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_evt.ready)
        else $error("empty input register refused an item");
`endif

endmodule

`default_nettype wire

[design/drkt_cfg.sv]
// APB configuration register file for the tap filter.
`timescale 1ns / 1ps
`default_nettype none

module drkt_cfg import drkt_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_psel,
    input  wire logic                     i_penable,
    input  wire logic                     i_pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] i_paddr,
    input  wire logic [APB_DATA_BITS-1:0] i_pwdata,
    output logic      [APB_DATA_BITS-1:0] o_prdata,
    output logic                          o_pready,
    output t_cfg                          o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel  = i_paddr[APB_ADDR_BITS-1:3];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_from_codes <= MAP_FROM_RESET;
            r_cfg.map_to_codes   <= MAP_TO_RESET;
            r_cfg.keys_in_use    <= KEYS_RESET;
            r_cfg.tap_window_us  <= WINDOW_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MAP_FROM:   r_cfg.map_from_codes <= i_pwdata[CFG_MAP_BITS-1:0];
                REG_MAP_TO:     r_cfg.map_to_codes   <= i_pwdata[CFG_MAP_BITS-1:0];
                REG_KEYS:       r_cfg.keys_in_use    <= i_pwdata[CFG_KEYS_BITS-1:0];
                REG_TAP_WINDOW: r_cfg.tap_window_us  <= i_pwdata[CFG_WINDOW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MAP_FROM:   o_prdata = APB_DATA_BITS'(r_cfg.map_from_codes);
            REG_MAP_TO:     o_prdata = APB_DATA_BITS'(r_cfg.map_to_codes);
            REG_KEYS:       o_prdata = APB_DATA_BITS'(r_cfg.keys_in_use);
            REG_TAP_WINDOW: o_prdata = APB_DATA_BITS'(r_cfg.tap_window_us);
            default:        o_prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/drkt_core.sv]
// Per-key state and the decision logic that turns one event into a result group.
`timescale 1ns / 1ps
`default_nettype none

module drkt_core import drkt_pkg::*; #(
    parameter int NUM_KEYS  = 6,
    parameter int CODE_BITS = 10,
    parameter int TIME_BITS = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_evt i_evt,
    input  wire t_cfg i_cfg,
    output t_group    o_grp,
    output logic      o_has_result
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PAD_W = CFG_MAP_BITS + NUM_KEYS * CODE_BITS;

    t_mode                r_mode    [NUM_KEYS];
    logic [TIME_BITS-1:0] r_press   [NUM_KEYS];
    logic [TIME_BITS-1:0] r_release [NUM_KEYS];

    logic [PAD_W-1:0]     from_pad;
    logic [PAD_W-1:0]     to_pad;
    logic [NUM_KEYS-1:0]  match;
    logic [15:0]          alt_code  [NUM_KEYS];
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [TIME_BITS-1:0] tm;
    logic [TIME_BITS-1:0] window;
    logic                 press_ok;
    logic                 release_ok;
    t_mode                cur_mode;
    t_mode                n_mode;
    logic                 wr_press;
    logic                 wr_release;
    logic [15:0]          code_out;
    logic                 three;

    assign from_pad = {{(NUM_KEYS * CODE_BITS){1'b0}}, i_cfg.map_from_codes};
    assign to_pad   = {{(NUM_KEYS * CODE_BITS){1'b0}}, i_cfg.map_to_codes};

    for (genvar i = 0; i < NUM_KEYS; i++) begin : g_entry
        localparam logic [4:0] KEY_NUM = 5'(i);
        assign match[i] = (KEY_NUM < {2'b00, i_cfg.keys_in_use})
                       && (i_evt.event_code == 16'(from_pad[i*CODE_BITS +: CODE_BITS]));
        assign alt_code[i] = 16'(to_pad[i*CODE_BITS +: CODE_BITS]);
    end

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign tm         = TIME_BITS'(i_evt.time_us);
    assign window     = TIME_BITS'(i_cfg.tap_window_us);
    assign press_ok   = (tm - r_press[hit_idx]) < window;
    assign release_ok = (tm - r_release[hit_idx]) < window;
    assign cur_mode   = r_mode[hit_idx];

    always_comb begin
        o_has_result = 1'b1;
        code_out     = i_evt.event_code;
        three        = 1'b0;
        n_mode       = cur_mode;
        wr_press     = 1'b0;
        wr_release   = 1'b0;
        if (i_evt.event_type == EV_MISC && i_evt.event_code == SCAN_CODE) begin
            o_has_result = 1'b0;
        end else if (i_evt.event_type != EV_KEY) begin
            o_has_result = 1'b1;
        end else if (i_evt.event_value == VAL_REPEAT) begin
            o_has_result = 1'b0;
        end else if (!hit) begin
            o_has_result = 1'b1;
        end else if (i_evt.event_value == VAL_PRESS) begin
            wr_press = 1'b1;
            case (cur_mode)
                MODE_IDLE: n_mode = MODE_PRESSED;
                MODE_TAPPED: begin
                    if (release_ok) begin
                        code_out = alt_code[hit_idx];
                    end else begin
                        n_mode = MODE_PRESSED;
                    end
                end
                default: ;
            endcase
        end else if (i_evt.event_value == VAL_RELEASE) begin
            wr_release = 1'b1;
            case (cur_mode)
                MODE_TAPPED: code_out = alt_code[hit_idx];
                MODE_PRESSED: begin
                    if (press_ok) begin
                        n_mode = MODE_TAPPED;
                        three  = 1'b1;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_grp                = '0;
        o_grp.evt            = i_evt;
        o_grp.evt.event_code = code_out;
        o_grp.alt_code       = alt_code[hit_idx];
        o_grp.three          = three;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_mode[i]    <= MODE_IDLE;
                r_press[i]   <= '0;
                r_release[i] <= '0;
            end
        end else if (i_fire && (wr_press || wr_release)) begin
            r_mode[hit_idx] <= n_mode;
            if (wr_press) begin
                r_press[hit_idx] <= tm;
            end
            if (wr_release) begin
                r_release[hit_idx] <= tm;
            end
        end
    end

endmodule

`default_nettype wire

[design/drkt_emit.sv]
// Result register that plays out a group of one or three result items.
`timescale 1ns / 1ps
`default_nettype none

module drkt_emit import drkt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_group i_grp,
    output logic        o_can_load,
    drkt_res_if.source  o_res
);

    logic   r_valid;
    t_beat  r_beat;
    t_group r_grp;
    logic   last;
    logic   done;

    assign last = (r_beat == BEAT_ALT_RELEASE) || (r_beat == BEAT_ORIG && !r_grp.three);
    assign done = r_valid && o_res.ready && last;
    assign o_can_load = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_ORIG;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_beat  <= BEAT_ORIG;
        end else if (done) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_ORIG;
        end else if (r_valid && o_res.ready) begin
            case (r_beat)
                BEAT_ORIG:      r_beat <= BEAT_ALT_PRESS;
                BEAT_ALT_PRESS: r_beat <= BEAT_ALT_RELEASE;
                default:        r_beat <= BEAT_ORIG;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

    always_comb begin
        o_res.valid       = r_valid;
        o_res.out_time    = r_grp.evt.time_us;
        o_res.last_of_run = last;
        case (r_beat)
            BEAT_ALT_PRESS: begin
                o_res.out_type  = EV_KEY;
                o_res.out_code  = r_grp.alt_code;
                o_res.out_value = VAL_PRESS;
            end
            BEAT_ALT_RELEASE: begin
                o_res.out_type  = EV_KEY;
                o_res.out_code  = r_grp.alt_code;
                o_res.out_value = VAL_RELEASE;
            end
            default: begin
                o_res.out_type  = r_grp.evt.event_type;
                o_res.out_code  = r_grp.evt.event_code;
                o_res.out_value = r_grp.evt.event_value;
            end
        endcase
    end

endmodule

`default_nettype wire
